// ===== sv/pvas_pkg.sv =====
package pvas_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DUP_RD,
    ST_DUP_CMP,
    ST_STORE,
    ST_INS_RD,
    ST_INS_WAIT,
    ST_CMP_RD,
    ST_CMP_WAIT,
    ST_CMP,
    ST_SHIFT,
    ST_PLACE,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT
  } state_t;

  typedef enum logic [0:0] {
    REG_CENTER_X = 1'b0,
    REG_CENTER_Y = 1'b1
  } reg_idx_t;

endpackage

// ===== sv/pvas_ram.sv =====
module pvas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pvas_order.sv =====
// Compare: stage 1 registers the two products, stage 2 decides from the registered values.
module pvas_order import pvas_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic [2*COORD_BITS-1:0]      a,
  input  logic [2*COORD_BITS-1:0]      b,
  input  logic                         sel_dist,
  output logic                         a_first,
  output logic                         tie
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] dxa, dya, dxb, dyb;
  logic signed [PW-1:0] p1_r, p2_r;
  logic                 ra_r, rb_r, za_r, zb_r, vrt_r, ygt_r, ylt_r;
  logic signed [PW:0]   diff;

  always_comb begin
    dxa = DW'(signed'(a[COORD_BITS-1:0])) - DW'(cx);
    dya = DW'(signed'(a[2*COORD_BITS-1:COORD_BITS])) - DW'(cy);
    dxb = DW'(signed'(b[COORD_BITS-1:0])) - DW'(cx);
    dyb = DW'(signed'(b[2*COORD_BITS-1:COORD_BITS])) - DW'(cy);
  end

  // sel_dist=0: cross terms; sel_dist=1: squared distances (second pass)
  always_ff @(posedge clk) begin
    if (sel_dist) begin
      p1_r <= PW'(dxa * dxa) + PW'(dya * dya);
      p2_r <= PW'(dxb * dxb) + PW'(dyb * dyb);
    end else begin
      p1_r <= PW'(dxa * dyb);
      p2_r <= PW'(dxb * dya);
    end
    ra_r  <= !dxa[DW-1];
    rb_r  <= !dxb[DW-1];
    za_r  <= (dxa == '0);
    zb_r  <= (dxb == '0);
    vrt_r <= !dya[DW-1] || !dyb[DW-1];
    ygt_r <= dya > dyb;
    ylt_r <= dya < dyb;
  end

  always_comb begin
    diff = (PW+1)'(p1_r) - (PW+1)'(p2_r);
    tie  = !sel_dist && (diff == '0) && (ra_r == rb_r) && !(za_r && zb_r);
    if (ra_r && !rb_r) begin
      a_first = 1'b1;
    end else if (!ra_r && rb_r) begin
      a_first = 1'b0;
    end else if (za_r && zb_r) begin
      a_first = vrt_r ? ygt_r : ylt_r;
    end else if (sel_dist) begin
      // farther point first
      a_first = !diff[PW] && (diff != '0);
    end else begin
      a_first = diff[PW];
    end
  end

endmodule

// ===== sv/polygon_vertex_angular_sort_top.sv =====
// Polygon vertex angular sort.
// Input channel in_*: one polygon edge per item (start point, end point,
// last_edge on tlast). Each endpoint is compared against the stored
// vertices one entry at a time; new points are appended to a RAM.
// On the last edge the vertices are insertion-sorted around the center
// (cfg registers) using one shared compare unit: each compare reads the
// sorted entry, registers the products and decides, with a second pass on
// squared distances when the cross product ties, then shifts or places,
// so a polygon of n vertices sorts in O(n^2) compares, then is
// streamed on out_* one vertex at a time; tlast marks the final vertex,
// tuser carries the overflow flag. in_tready is low while work is under way.
// If out_tready is low the block holds the current vertex and waits.
// Reset clears the center, the vertex count and the overflow flag.
module polygon_vertex_angular_sort_top import pvas_pkg::*; #(
  parameter int MAX_VERTICES = 32,
  parameter int COORD_BITS   = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // start_x, start_y, end_x, end_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                      in_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // vertex_x, vertex_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0] out_tdata,
  output logic                      out_tlast,
  // overflowed
  output logic                      out_tuser,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [2:0]                cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int PTW = 2 * COORD_BITS;
  localparam int OW  = ((2*COORD_BITS+7)/8)*8;

  state_t state_r, state_nxt;

  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic [CW-1:0] cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt;
  logic          ovf_r, ovf_nxt, last_r, last_nxt, half_r, half_nxt, dist_r, dist_nxt;
  logic [PTW-1:0] p_r, p_nxt, e_r, e_nxt, x_r, x_nxt;
  logic [PTW-1:0] stv_rd, srt_rd, prev_r, prev_nxt;

  logic          st_we, so_we;
  logic [AW-1:0] st_wa, st_ra, so_wa, so_ra;
  logic [PTW-1:0] st_wd, so_wd;
  logic          a_first, tie;

  reg_idx_t widx;
  logic     wr;

  assign cfg_pready = 1'b1;
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign widx = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      case (widx)
        REG_CENTER_X: cx_r <= cfg_pwdata[COORD_BITS-1:0];
        REG_CENTER_Y: cy_r <= cfg_pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[2]))
      REG_CENTER_X: cfg_prdata = 32'(signed'(cx_r));
      REG_CENTER_Y: cfg_prdata = 32'(signed'(cy_r));
      default:      cfg_prdata = '0;
    endcase
  end

  pvas_ram #(.WIDTH(PTW), .DEPTH(MAX_VERTICES)) u_store (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(stv_rd)
  );

  pvas_ram #(.WIDTH(PTW), .DEPTH(MAX_VERTICES)) u_sorted (
    .clk(clk), .we(so_we), .waddr(so_wa), .wdata(so_wd), .raddr(so_ra), .rdata(srt_rd)
  );

  pvas_order #(.COORD_BITS(COORD_BITS)) u_order (
    .clk(clk), .cx(cx_r), .cy(cy_r), .a(x_r), .b(prev_r),
    .sel_dist(dist_r), .a_first(a_first), .tie(tie)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
    i_r <= i_nxt;  j_r <= j_nxt;  last_r <= last_nxt;  half_r <= half_nxt;
    dist_r <= dist_nxt;  p_r <= p_nxt;  e_r <= e_nxt;  x_r <= x_nxt;
    prev_r <= prev_nxt;
  end

  logic [CW-1:0] jm1;
  assign jm1 = j_r - 1'b1;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;  ovf_nxt = ovf_r;  i_nxt = i_r;  j_nxt = j_r;
    last_nxt = last_r;  half_nxt = half_r;  dist_nxt = dist_r;
    p_nxt = p_r;  e_nxt = e_r;  x_nxt = x_r;  prev_nxt = prev_r;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    st_we = 1'b0;  st_wa = cnt_r[AW-1:0];  st_wd = p_r;  st_ra = i_r[AW-1:0];
    so_we = 1'b0;  so_wa = j_r[AW-1:0];    so_wd = x_r;  so_ra = jm1[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          p_nxt = in_tdata[PTW-1:0];
          e_nxt = in_tdata[2*PTW-1:PTW];
          last_nxt = in_tlast;
          half_nxt = 1'b0;
          i_nxt = '0;
          state_nxt = ST_DUP_RD;
        end
      end
      ST_DUP_RD: begin
        if (i_r == cnt_r) begin
          state_nxt = ST_STORE;
        end else begin
          state_nxt = ST_DUP_CMP;
        end
      end
      ST_DUP_CMP: begin
        if (stv_rd == p_r) begin
          i_nxt = '0;
          half_nxt = 1'b1;
          p_nxt = e_r;
          state_nxt = half_r ? ST_INS_RD : ST_DUP_RD;
          if (half_r) i_nxt = '0;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = ST_DUP_RD;
        end
      end
      ST_STORE: begin
        if (cnt_r == CW'(MAX_VERTICES)) begin
          ovf_nxt = 1'b1;
        end else begin
          st_we = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        i_nxt = '0;
        half_nxt = 1'b1;
        p_nxt = e_r;
        state_nxt = half_r ? ST_INS_RD : ST_DUP_RD;
      end
      ST_INS_RD: begin
        // i_r: next vertex to insert
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (i_r == cnt_r) begin
          j_nxt = '0;
          state_nxt = ST_OUT_RD;
        end else begin
          state_nxt = ST_INS_WAIT;
        end
      end
      ST_INS_WAIT: begin
        x_nxt = stv_rd;
        j_nxt = i_r;
        state_nxt = ST_CMP_RD;
      end
      ST_CMP_RD: begin
        dist_nxt = 1'b0;
        state_nxt = (j_r == '0) ? ST_PLACE : ST_CMP_WAIT;
      end
      ST_CMP_WAIT: begin
        prev_nxt = srt_rd;
        state_nxt = ST_CMP;
        half_nxt = 1'b0;
      end
      ST_CMP: begin
        // first pass: register products; then decide
        if (!half_r) begin
          half_nxt = 1'b1;
        end else if (a_first) begin
          state_nxt = ST_SHIFT;
        end else if (tie) begin
          dist_nxt = 1'b1;
          half_nxt = 1'b0;
        end else begin
          state_nxt = ST_PLACE;
        end
      end
      ST_SHIFT: begin
        so_we = 1'b1;
        so_wd = prev_r;
        j_nxt = jm1;
        state_nxt = ST_CMP_RD;
      end
      ST_PLACE: begin
        so_we = 1'b1;
        i_nxt = i_r + 1'b1;
        state_nxt = ST_INS_RD;
      end
      ST_OUT_RD: begin
        so_ra = j_r[AW-1:0];
        state_nxt = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        prev_nxt = srt_rd;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          j_nxt = j_r + 1'b1;
          if (j_r + 1'b1 == cnt_r) begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tdata = OW'(prev_r);
  assign out_tlast = (j_r + 1'b1 == cnt_r);
  assign out_tuser = ovf_r;

endmodule

// ===== bench/tb.sv =====
module tb import pvas_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NVERT      = 32;
  localparam int IDLE_LIMIT = 50000;
  localparam int SETTLE     = 400;

  typedef struct {
    shortint x;
    shortint y;
    bit      last;
    bit      ovf;
  } vertex_t;

  typedef struct {
    shortint x0, y0, x1, y1;
    bit      last;
    bit      typed;
    shortint tx, ty;
  } edge_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  polygon_vertex_angular_sort_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  shortint center_x_m, center_y_m;
  shortint pts_x[$];
  shortint pts_y[$];
  bit      dropped;
  vertex_t sorted_q[$];
  int      mismatches;
  int      vertices_seen;
  int      idle_cycles;
  int      edges_sent;
  bit      no_gaps;

  function automatic bit precedes(shortint ax, shortint ay, shortint bx, shortint by);
    longint dxa, dya, dxb, dyb, cr;
    dxa = longint'(ax) - longint'(center_x_m);
    dya = longint'(ay) - longint'(center_y_m);
    dxb = longint'(bx) - longint'(center_x_m);
    dyb = longint'(by) - longint'(center_y_m);
    if (dxa >= 0 && dxb < 0) return 1'b1;
    if (dxa < 0 && dxb >= 0) return 1'b0;
    if (dxa == 0 && dxb == 0) begin
      if (dya >= 0 || dyb >= 0) return ay > by;
      return by > ay;
    end
    cr = dxa * dyb - dxb * dya;
    if (cr < 0) return 1'b1;
    if (cr > 0) return 1'b0;
    return (dxa * dxa + dya * dya) > (dxb * dxb + dyb * dyb);
  endfunction

  function automatic void keep_point(shortint x, shortint y);
    foreach (pts_x[k])
      if (pts_x[k] == x && pts_y[k] == y) return;
    if (pts_x.size() >= NVERT) begin
      dropped = 1'b1;
      return;
    end
    pts_x = {pts_x, x};
    pts_y = {pts_y, y};
  endfunction

  // returns the sorted polygon, or nothing if the edge is not the last one
  function automatic void sort_polygon(edge_row_t e, ref vertex_t res[$]);
    shortint sx[NVERT], sy[NVERT];
    int n, j;
    vertex_t v;
    res.delete();
    keep_point(e.x0, e.y0);
    keep_point(e.x1, e.y1);
    if (!e.last) return;
    n = pts_x.size();
    for (int i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && precedes(pts_x[i], pts_y[i], sx[j-1], sy[j-1])) begin
        sx[j] = sx[j-1];
        sy[j] = sy[j-1];
        j--;
      end
      sx[j] = pts_x[i];
      sy[j] = pts_y[i];
    end
    for (int i = 0; i < n; i++) begin
      v.x = sx[i];
      v.y = sy[i];
      v.last = (i == n - 1);
      v.ovf = dropped;
      res = {res, v};
    end
    pts_x.delete();
    pts_y.delete();
    dropped = 1'b0;
  endfunction

  task automatic send_edge(edge_row_t e);
    vertex_t res[$];
    vertex_t v;
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {e.y1, e.x1, e.y0, e.x0};
    in_tlast  <= e.last;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    edges_sent++;
    sort_polygon(e, res);
    if (e.typed) begin
      v.x = e.tx;
      v.y = e.ty;
      v.last = 1'b1;
      v.ovf = 1'b0;
      sorted_q = {sorted_q, v};
    end else begin
      foreach (res[i]) sorted_q = {sorted_q, res[i]};
    end
  endtask

  task automatic write_reg(reg_idx_t idx, shortint val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(int'(idx) * 4);
    cfg_pwdata  <= {{16{val[15]}}, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_CENTER_X) center_x_m = val;
    else center_y_m = val;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    wait (sorted_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic shortint pick_coord(shortint c);
    case ($urandom_range(0, 3))
      0: return shortint'($urandom);
      1: return c;
      default: return c + shortint'($urandom_range(0, 16)) - 8;
    endcase
  endfunction

  task automatic random_polygon;
    edge_row_t e;
    shortint fx, fy, px, py;
    int k;
    bit big;
    big = ($urandom_range(0, 9) == 0);
    k = big ? $urandom_range(17, 22) : $urandom_range(1, 10);
    no_gaps = ($urandom_range(0, 3) == 0);
    fx = pick_coord(center_x_m);
    fy = pick_coord(center_y_m);
    px = fx;
    py = fy;
    for (int i = 0; i < k; i++) begin
      e.x0 = ($urandom_range(0, 4) == 0 || big) ? shortint'($urandom) : px;
      e.y0 = ($urandom_range(0, 4) == 0 || big) ? shortint'($urandom) : py;
      e.x1 = big ? shortint'($urandom) : pick_coord(center_x_m);
      e.y1 = big ? shortint'($urandom) : pick_coord(center_y_m);
      e.last = (i == k - 1);
      e.typed = 1'b0;
      if (e.last && !big && $urandom_range(0, 1)) begin
        e.x1 = fx;
        e.y1 = fy;
      end
      px = e.x1;
      py = e.y1;
      send_edge(e);
    end
  endtask

  edge_row_t directed[] = '{
    '{-32768, -32768, -32768, -32768, 1, 1, -32768, -32768},
    '{32767, 32767, 32767, 32767, 1, 1, 32767, 32767},
    '{0, 0, 0, 0, 1, 1, 0, 0},
    '{10, 0, 0, -10, 0, 0, 0, 0},
    '{0, -10, -10, 5, 0, 0, 0, 0},
    '{-10, 5, 10, 0, 1, 0, 0, 0},
    '{0, 5, 0, -3, 0, 0, 0, 0},
    '{0, -3, 0, 9, 1, 0, 0, 0},
    '{0, -7, 0, -2, 0, 0, 0, 0},
    '{0, -2, 0, -9, 1, 0, 0, 0},
    '{3, 3, 6, 6, 0, 0, 0, 0},
    '{6, 6, -4, -4, 0, 0, 0, 0},
    '{-4, -4, -2, -2, 1, 0, 0, 0},
    '{32767, 0, 0, 32767, 0, 0, 0, 0},
    '{-32768, 0, 0, -32768, 0, 0, 0, 0},
    '{32767, -32768, -32768, 32767, 1, 0, 0, 0},
    '{1, 2, 3, 4, 0, 0, 0, 0},
    '{1, 2, 3, 4, 0, 0, 0, 0},
    '{3, 4, 1, 2, 1, 0, 0, 0},
    '{0, 4, 5, -5, 0, 0, 0, 0},
    '{0, -4, -5, 5, 1, 0, 0, 0}
  };

  // receiver: random stalls, one long hold-off early on
  initial begin
    int w;
    bit held;
    held = 1'b0;
    out_tready <= 1'b0;
    forever begin
      if (!held && vertices_seen >= 5) begin
        held = 1'b1;
        w = 3000;
      end else begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      end
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin
    vertex_t v;
    if (rst_n && out_tvalid && out_tready) begin
      vertices_seen++;
      if (sorted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected vertex x=%0d y=%0d", $signed(out_tdata[15:0]),
                   $signed(out_tdata[31:16]));
      end else begin
        v = sorted_q.pop_front();
        if (out_tdata[15:0] !== v.x || out_tdata[31:16] !== v.y ||
            out_tlast !== v.last || out_tuser !== v.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d,%0d l=%0b o=%0b, got %0d,%0d l=%0b o=%0b",
                     v.x, v.y, v.last, v.ovf, $signed(out_tdata[15:0]),
                     $signed(out_tdata[31:16]), out_tlast, out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    shortint cx[4], cy[4];
    mismatches    = 0;
    vertices_seen = 0;
    idle_cycles   = 0;
    edges_sent    = 0;
    no_gaps       = 1'b0;
    center_x_m    = 0;
    center_y_m    = 0;
    dropped       = 1'b0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_edge(directed[i]);
    drain();

    cx = '{0, -32768, 32767, shortint'($urandom)};
    cy = '{0, 32767, -32768, shortint'($urandom)};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_CENTER_X, cx[ph]);
      write_reg(REG_CENTER_Y, cy[ph]);
      while (edges_sent < directed.size() + 60 * (ph + 1)) random_polygon();
      drain();
    end

    if (mismatches == 0 && sorted_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
sv/pvas_pkg.sv
sv/pvas_ram.sv
sv/pvas_order.sv
sv/polygon_vertex_angular_sort_top.sv
bench/tb.sv
